/* rtl/isfp_pkg.sv */
// Shared constants and types for the IMU serial frame parser.
package isfp_pkg;

   localparam int MAX_FRAME     = 64;
   localparam int BYTE_W        = 8;
   localparam int FRAME_BYTES_W = 7;
   localparam int POS_W         = 6;
   localparam int CNT_W         = $clog2(MAX_FRAME + 1);
   localparam int CMP_W         = (CNT_W > FRAME_BYTES_W) ? CNT_W : FRAME_BYTES_W;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 8;

   localparam logic [FRAME_BYTES_W-1:0] IMU_FRAME_BYTES_RST  = FRAME_BYTES_W'(64);
   localparam logic [FRAME_BYTES_W-1:0] AHRS_FRAME_BYTES_RST = FRAME_BYTES_W'(56);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HEAD_BYTE        = 3'd0,
      CSR_END_BYTE         = 3'd1,
      CSR_IMU_TYPE_CODE    = 3'd2,
      CSR_IMU_LENGTH_CODE  = 3'd3,
      CSR_AHRS_TYPE_CODE   = 3'd4,
      CSR_AHRS_LENGTH_CODE = 3'd5,
      CSR_IMU_FRAME_BYTES  = 3'd6,
      CSR_AHRS_FRAME_BYTES = 3'd7
   } csr_index_type;

   typedef enum logic {
      KIND_IMU  = 1'b0,
      KIND_AHRS = 1'b1
   } frame_kind_type;

endpackage

/* rtl/imu_serial_frame_parser.sv */
// Byte-stream frame parser: finds IMU and attitude frames and tags each byte.
//
// One received byte is taken per transaction, one result per byte. A byte can be
// accepted in every clock cycle that is not stalled; its result appears in the
// output register on the next cycle. The single output register is the only
// buffering, so the input stalls only while that register holds a result the
// downstream side is stalling on. Frame state (byte count, latched type and
// length, match flags) is registered at the same clock edge as the result.
// Configuration registers take effect on the next accepted byte.
module imu_serial_frame_parser
   import isfp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [BYTE_W-1:0]     req_rx_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [BYTE_W-1:0]     rsp_byte_out,
   output logic [POS_W-1:0]      rsp_position,
   output logic                  rsp_in_frame,
   output logic                  rsp_frame_done,
   output logic                  rsp_frame_kind,
   output logic                  rsp_end_ok,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   logic [BYTE_W-1:0]        head_byte_ff, end_byte_ff;
   logic [BYTE_W-1:0]        imu_type_ff, imu_length_ff;
   logic [BYTE_W-1:0]        ahrs_type_ff, ahrs_length_ff;
   logic [FRAME_BYTES_W-1:0] imu_frame_bytes_ff, ahrs_frame_bytes_ff;

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [BYTE_W-1:0] prev_ff, prev_in;
   logic [BYTE_W-1:0] type_ff, type_in;
   logic [BYTE_W-1:0] length_ff, length_in;
   logic              imu_match_ff, imu_match_in;
   logic              ahrs_match_ff, ahrs_match_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] byte_ff;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              in_frame_ff, in_frame_in;
   logic              done_ff, done_in;
   logic              kind_ff, kind_in;
   logic              end_ok_ff, end_ok_in;

   logic              req_accept;
   logic              rsp_accept;
   logic [CNT_W-1:0]  count_next;
   logic              imu_m, ahrs_m;

   assign rsp_accept = rsp_valid_ff && !rsp_stall;
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      count_in      = count_ff;
      prev_in       = prev_ff;
      type_in       = type_ff;
      length_in     = length_ff;
      imu_match_in  = imu_match_ff;
      ahrs_match_in = ahrs_match_ff;
      pos_in        = '0;
      in_frame_in   = 1'b0;
      done_in       = 1'b0;
      kind_in       = KIND_IMU;
      end_ok_in     = 1'b0;
      imu_m         = 1'b0;
      ahrs_m        = 1'b0;
      count_next    = '0;
      rsp_valid_in  = rsp_valid_ff;

      if (rsp_accept) begin
         rsp_valid_in = 1'b0;
      end

      if (req_accept) begin
         rsp_valid_in = 1'b1;
         prev_in      = req_rx_byte;
         if (count_ff != '0 || (prev_ff == end_byte_ff && req_rx_byte == head_byte_ff)) begin
            imu_m  = (count_ff == '0) ? 1'b0 : imu_match_ff;
            ahrs_m = (count_ff == '0) ? 1'b0 : ahrs_match_ff;
            if (count_ff == CNT_W'(1)) begin
               type_in = req_rx_byte;
            end
            if (count_ff == CNT_W'(2)) begin
               length_in = req_rx_byte;
            end
            if (count_ff >= CNT_W'(2)) begin
               if (type_in == imu_type_ff && length_in == imu_length_ff) begin
                  imu_m = 1'b1;
               end
               if (type_in == ahrs_type_ff && length_in == ahrs_length_ff) begin
                  ahrs_m = 1'b1;
               end
            end
            pos_in      = POS_W'(count_ff);
            in_frame_in = 1'b1;
            count_next  = count_ff + CNT_W'(1);

            if (imu_m && CMP_W'(count_next) == CMP_W'(imu_frame_bytes_ff)) begin
               done_in = 1'b1;
               kind_in = KIND_IMU;
            end else if (ahrs_m && CMP_W'(count_next) == CMP_W'(ahrs_frame_bytes_ff)) begin
               done_in = 1'b1;
               kind_in = KIND_AHRS;
            end

            if (done_in) begin
               end_ok_in     = (req_rx_byte == end_byte_ff);
               count_in      = '0;
               imu_match_in  = 1'b0;
               ahrs_match_in = 1'b0;
            end else if (count_next >= CNT_W'(MAX_FRAME)) begin
               count_in      = '0;
               imu_match_in  = 1'b0;
               ahrs_match_in = 1'b0;
            end else begin
               count_in      = count_next;
               imu_match_in  = imu_m;
               ahrs_match_in = ahrs_m;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_byte_ff        <= '0;
         end_byte_ff         <= '0;
         imu_type_ff         <= '0;
         imu_length_ff       <= '0;
         ahrs_type_ff        <= '0;
         ahrs_length_ff      <= '0;
         imu_frame_bytes_ff  <= IMU_FRAME_BYTES_RST;
         ahrs_frame_bytes_ff <= AHRS_FRAME_BYTES_RST;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_HEAD_BYTE:        head_byte_ff        <= csr_write_data;
            CSR_END_BYTE:         end_byte_ff         <= csr_write_data;
            CSR_IMU_TYPE_CODE:    imu_type_ff         <= csr_write_data;
            CSR_IMU_LENGTH_CODE:  imu_length_ff       <= csr_write_data;
            CSR_AHRS_TYPE_CODE:   ahrs_type_ff        <= csr_write_data;
            CSR_AHRS_LENGTH_CODE: ahrs_length_ff      <= csr_write_data;
            CSR_IMU_FRAME_BYTES:  imu_frame_bytes_ff  <= csr_write_data[FRAME_BYTES_W-1:0];
            CSR_AHRS_FRAME_BYTES: ahrs_frame_bytes_ff <= csr_write_data[FRAME_BYTES_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         prev_ff       <= '0;
         type_ff       <= '0;
         length_ff     <= '0;
         imu_match_ff  <= 1'b0;
         ahrs_match_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         prev_ff       <= prev_in;
         type_ff       <= type_in;
         length_ff     <= length_in;
         imu_match_ff  <= imu_match_in;
         ahrs_match_ff <= ahrs_match_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         byte_ff     <= req_rx_byte;
         pos_ff      <= pos_in;
         in_frame_ff <= in_frame_in;
         done_ff     <= done_in;
         kind_ff     <= kind_in;
         end_ok_ff   <= end_ok_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_byte_out   = byte_ff;
   assign rsp_position   = pos_ff;
   assign rsp_in_frame   = in_frame_ff;
   assign rsp_frame_done = done_ff;
   assign rsp_frame_kind = kind_ff;
   assign rsp_end_ok     = end_ok_ff;

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff < CNT_W'(MAX_FRAME))
      else $error("byte count reached the frame limit");

   a_idle_flags_clear: assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> !imu_match_ff && !ahrs_match_ff)
      else $error("match flag set outside a frame");

   a_done_ends_frame: assert property (@(posedge clock) disable iff (reset)
      req_accept && done_in |=> count_ff == '0)
      else $error("frame still open after completion");

   a_done_in_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_frame_done |-> rsp_in_frame)
      else $error("completion reported outside a frame");

   a_end_ok_needs_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_end_ok || rsp_frame_kind) |-> rsp_frame_done)
      else $error("end or kind flag without completion");
`endif

endmodule

/* bench/imu_serial_frame_parser_test.sv */
// Self-checking bench for the IMU serial frame parser: frame streams under random flow control.
module imu_serial_frame_parser_test
   import isfp_pkg::*;
;

   localparam int STALL_LIMIT = 2000;

   typedef struct {
      logic [BYTE_W-1:0] byte_out;
      logic [POS_W-1:0]  position;
      logic              in_frame;
      logic              frame_done;
      frame_kind_type    frame_kind;
      logic              end_ok;
   } byte_tag_type;

   typedef logic [CSR_DATA_W-1:0] reg_image_type [8];

   class frame_tag_checker;
      logic [7:0] head_code, end_code, imu_type, imu_len, ahrs_type, att_length;
      logic [6:0] imu_size, ahrs_size;
      logic [6:0] count;
      logic [7:0] last_byte, type_seen, len_seen;
      bit         imu_hit, ahrs_hit;
      byte_tag_type due_tags[$];
      int         errors;

      function new();
         head_code = '0; end_code = '0; imu_type = '0; imu_len = '0;
         ahrs_type = '0; att_length = '0;
         imu_size = IMU_FRAME_BYTES_RST; ahrs_size = AHRS_FRAME_BYTES_RST;
         count = '0; last_byte = '0; type_seen = '0; len_seen = '0;
         imu_hit = 0; ahrs_hit = 0; errors = 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [7:0] v);
         case (idx)
            CSR_HEAD_BYTE:        head_code  = v;
            CSR_END_BYTE:         end_code   = v;
            CSR_IMU_TYPE_CODE:    imu_type   = v;
            CSR_IMU_LENGTH_CODE:  imu_len    = v;
            CSR_AHRS_TYPE_CODE:   ahrs_type  = v;
            CSR_AHRS_LENGTH_CODE: att_length = v;
            CSR_IMU_FRAME_BYTES:  imu_size   = v[6:0];
            CSR_AHRS_FRAME_BYTES: ahrs_size  = v[6:0];
            default: ;
         endcase
      endfunction

      function void note_byte(logic [7:0] b);
         byte_tag_type t;
         logic [6:0]   pos;
         t = '{byte_out: b, position: '0, in_frame: 1'b0, frame_done: 1'b0,
               frame_kind: KIND_IMU, end_ok: 1'b0};
         if (count != 0 || (last_byte == end_code && b == head_code)) begin
            if (count == 0) begin
               imu_hit = 0;
               ahrs_hit = 0;
            end
            pos = count;
            t.in_frame = 1'b1;
            t.position = pos[5:0];
            if (pos == 1) type_seen = b;
            if (pos == 2) len_seen = b;
            if (pos >= 2) begin
               if (type_seen == imu_type && len_seen == imu_len) imu_hit = 1;
               if (type_seen == ahrs_type && len_seen == att_length) ahrs_hit = 1;
            end
            count = pos + 7'd1;
            if (imu_hit && count == imu_size) begin
               t.frame_done = 1'b1;
               t.frame_kind = KIND_IMU;
            end else if (ahrs_hit && count == ahrs_size) begin
               t.frame_done = 1'b1;
               t.frame_kind = KIND_AHRS;
            end
            if (t.frame_done) begin
               t.end_ok = (b == end_code);
               count = '0;
               imu_hit = 0;
               ahrs_hit = 0;
            end else if (count >= MAX_FRAME) begin
               count = '0;
               imu_hit = 0;
               ahrs_hit = 0;
            end
         end
         last_byte = b;
         due_tags.push_back(t);
      endfunction

      function void compare(string name, logic [7:0] want, logic [7:0] got);
         if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_tag(byte_tag_type got);
         byte_tag_type want;
         if (due_tags.size() == 0) begin
            $error("unexpected transaction: byte_out %0h", got.byte_out);
            errors++;
            return;
         end
         want = due_tags.pop_front();
         compare("byte_out", want.byte_out, got.byte_out);
         compare("position", 8'(want.position), 8'(got.position));
         compare("in_frame", 8'(want.in_frame), 8'(got.in_frame));
         compare("frame_done", 8'(want.frame_done), 8'(got.frame_done));
         compare("frame_kind", 8'(want.frame_kind), 8'(got.frame_kind));
         compare("end_ok", 8'(want.end_ok), 8'(got.end_ok));
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [BYTE_W-1:0]     req_rx_byte = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [BYTE_W-1:0]     rsp_byte_out;
   logic [POS_W-1:0]      rsp_position;
   logic                  rsp_in_frame;
   logic                  rsp_frame_done;
   logic                  rsp_frame_kind;
   logic                  rsp_end_ok;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   frame_tag_checker sb = new();
   byte_tag_type seen_tag;
   int sent = 0;
   int stuck = 0;
   int rsp_hold = 0;
   bit quiet_tx = 0;
   bit quiet_rx = 0;

   imu_serial_frame_parser DUT (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic int idle_draw();
      return $urandom_range(0, 1) ? 0 : int'($urandom_range(0, 18));
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_byte(req_rx_byte);
         if (rsp_valid && !rsp_stall) begin
            seen_tag.byte_out   = rsp_byte_out;
            seen_tag.position   = rsp_position;
            seen_tag.in_frame   = rsp_in_frame;
            seen_tag.frame_done = rsp_frame_done;
            seen_tag.frame_kind = frame_kind_type'(rsp_frame_kind);
            seen_tag.end_ok     = rsp_end_ok;
            sb.check_tag(seen_tag);
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) stuck = 0;
         else stuck++;
         if (stuck >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if ($urandom_range(0, 79) == 0) quiet_rx = !quiet_rx;
            rsp_hold = quiet_rx ? 0 : idle_draw();
         end
         rsp_stall <= (rsp_hold > 0);
         if (rsp_hold > 0) rsp_hold--;
      end
   end

   task automatic send_byte(input logic [7:0] b);
      int gap;
      if ($urandom_range(0, 79) == 0) quiet_tx = !quiet_tx;
      gap = quiet_tx ? 0 : idle_draw();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.due_tags.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_regs(input reg_image_type img);
      csr_index_type r;
      r = r.first();
      do begin
         csr_write_enable <= 1'b1;
         csr_index        <= r;
         csr_write_data   <= img[r];
         sb.set_reg(r, img[r]);
         @(posedge clock);
         r = r.next();
      end while (r != r.first());
      csr_write_enable <= 1'b0;
   endtask

   task automatic send_frame(input bit broken);
      bit         ahrs;
      logic [7:0] ty, ln, b;
      int         total, cut;
      ahrs  = 1'($urandom_range(0, 1));
      ty    = ahrs ? sb.ahrs_type : sb.imu_type;
      ln    = ahrs ? sb.att_length : sb.imu_len;
      total = int'(ahrs ? sb.ahrs_size : sb.imu_size);
      if (total > MAX_FRAME + 2) total = MAX_FRAME + 2;
      cut = total;
      if (broken) begin
         case ($urandom_range(0, 2))
            0: ty = 8'($urandom);
            1: ln = 8'($urandom);
            default: cut = (total > 1) ? int'($urandom_range(1, total - 1)) : total;
         endcase
      end
      send_byte(sb.end_code);
      for (int i = 0; i < cut; i++) begin
         if (i == 0) b = sb.head_code;
         else if (i == 1) b = ty;
         else if (i == 2) b = ln;
         else if (i == total - 1 && $urandom_range(0, 4) != 0) b = sb.end_code;
         else b = 8'($urandom);
         send_byte(b);
      end
   endtask

   task automatic run_phase(input reg_image_type img, input int budget);
      int stop;
      int pick;
      wait_idle();
      program_regs(img);
      stop = sent + budget;
      while (sent < stop) begin
         pick = int'($urandom_range(0, 99));
         if (pick < 2) begin
            wait_idle();
         end else if (pick < 72) begin
            send_frame(1'b0);
         end else if (pick < 87) begin
            send_frame(1'b1);
         end else begin
            repeat ($urandom_range(1, 6)) begin
               case ($urandom_range(0, 7))
                  0, 1:    send_byte(sb.end_code);
                  2:       send_byte(sb.head_code);
                  default: send_byte(8'($urandom));
               endcase
            end
         end
      end
   endtask

   function automatic reg_image_type random_image(input int max_size);
      reg_image_type img;
      img[CSR_HEAD_BYTE]        = 8'($urandom);
      img[CSR_END_BYTE]         = 8'($urandom);
      img[CSR_IMU_TYPE_CODE]    = 8'($urandom);
      img[CSR_IMU_LENGTH_CODE]  = 8'($urandom);
      img[CSR_AHRS_TYPE_CODE]   = 8'($urandom);
      img[CSR_AHRS_LENGTH_CODE] = 8'($urandom);
      img[CSR_IMU_FRAME_BYTES]  = 8'($urandom_range(4, max_size));
      img[CSR_AHRS_FRAME_BYTES] = 8'($urandom_range(4, max_size));
      return img;
   endfunction

   initial begin
      reg_image_type img;
      logic [7:0] opening[$];
      opening = '{8'h01, 8'h10, 8'h55, 8'hAA, 8'h02, 8'h20, 8'hFF, 8'h00,
                  8'hFF, 8'h55, 8'hAA, 8'h02, 8'h20, 8'h55, 8'hAA, 8'h00};
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // zero byte straight out of reset opens a frame
      send_byte(8'h00);
      wait_idle();
      img[CSR_HEAD_BYTE]        = 8'hAA;
      img[CSR_END_BYTE]         = 8'h55;
      img[CSR_IMU_TYPE_CODE]    = 8'h01;
      img[CSR_IMU_LENGTH_CODE]  = 8'h10;
      img[CSR_AHRS_TYPE_CODE]   = 8'h02;
      img[CSR_AHRS_LENGTH_CODE] = 8'h20;
      img[CSR_IMU_FRAME_BYTES]  = 8'd4;
      img[CSR_AHRS_FRAME_BYTES] = 8'd5;
      program_regs(img);
      foreach (opening[i]) send_byte(opening[i]);

      run_phase(random_image(20), 120);

      img[CSR_HEAD_BYTE]        = 8'hFF;
      img[CSR_END_BYTE]         = 8'h00;
      img[CSR_IMU_TYPE_CODE]    = 8'h00;
      img[CSR_IMU_LENGTH_CODE]  = 8'hFF;
      img[CSR_AHRS_TYPE_CODE]   = 8'hFF;
      img[CSR_AHRS_LENGTH_CODE] = 8'h00;
      img[CSR_IMU_FRAME_BYTES]  = 8'd64;
      img[CSR_AHRS_FRAME_BYTES] = 8'd4;
      run_phase(img, 200);

      // both kinds share one header
      img = random_image(12);
      img[CSR_AHRS_TYPE_CODE]   = img[CSR_IMU_TYPE_CODE];
      img[CSR_AHRS_LENGTH_CODE] = img[CSR_IMU_LENGTH_CODE];
      run_phase(img, 100);

      // sizes that can never complete
      img = random_image(8);
      img[CSR_IMU_FRAME_BYTES]  = 8'd2;
      img[CSR_AHRS_FRAME_BYTES] = 8'hFF;
      run_phase(img, 80);
      img[CSR_IMU_FRAME_BYTES]  = 8'd0;
      img[CSR_AHRS_FRAME_BYTES] = 8'd1;
      run_phase(img, 40);

      img = random_image(16);
      img[CSR_END_BYTE] = img[CSR_HEAD_BYTE];
      run_phase(img, 100);

      repeat (3) run_phase(random_image(64), 80);

      wait_idle();
      if (sb.errors == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule

/* files.f */
rtl/isfp_pkg.sv
rtl/imu_serial_frame_parser.sv
bench/imu_serial_frame_parser_test.sv
